@@ rtl/core/cbms_pkg.sv @@
// Shared types and constants for the cosine best-match search block.
package cbms_pkg;

	// Default sizes
	localparam int MAX_ENTRIES_DEF = 64;
	localparam int EMBED_LEN_DEF   = 512;

	// Configuration register indexes
	localparam logic [1:0] CFG_ENTRY_COUNT   = 2'd0;
	localparam logic [1:0] CFG_VECTOR_LENGTH = 2'd1;
	localparam logic [1:0] CFG_MATCH_THRESH  = 2'd2;

	// Q1.15 score limits
	localparam logic signed [15:0] SCORE_MIN = 16'sh8000;
	localparam logic signed [15:0] SCORE_MAX = 16'sh7FFF;

	// Input beat
	typedef struct packed {
		logic              kind;
		logic [5:0]        entry;
		logic [8:0]        position;
		logic signed [15:0] value;
		logic              last;
	} in_beat_t;

	// Result beat
	typedef struct packed {
		logic              matched;
		logic [5:0]        best_entry;
		logic signed [15:0] score;
	} res_beat_t;

endpackage

@@ rtl/core/cbms_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
module cbms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/cbms_score.sv @@
// Iterative scorer: two integer square roots, shift-add product, restoring divide.
module cbms_score import cbms_pkg::*; #(
	parameter int ACC_W = 41
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic signed [ACC_W-1:0] dot,
	input  logic [ACC_W-1:0]        na,
	input  logic [ACC_W-1:0]        nb,
	output logic                    done,
	output logic signed [15:0]      score
);
	localparam int SQ_W  = ACC_W + (ACC_W % 2);
	localparam int RT_W  = SQ_W / 2;
	localparam int DEN_W = 2 * RT_W;
	localparam int NUM_W = ACC_W + 15;
	localparam int CW    = $clog2(NUM_W + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQRT = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;

	logic [2:0]       st_q;
	logic [CW-1:0]    cnt_q;
	logic [SQ_W-1:0]  xa_q, ra_q, xb_q, rb_q, bit_q;
	logic [SQ_W-1:0]  xa_n, ra_n, xb_n, rb_n, ta, tb;
	logic             neg_q;
	logic [NUM_W-1:0] num_q, quo_q, quo_n;
	logic [DEN_W-1:0] mcand_q, den_q, den_n;
	logic [RT_W-1:0]  mplr_q;
	logic [DEN_W:0]   rem_q, rem_sh, rem_n;
	logic [ACC_W-1:0] mag;
	logic signed [15:0] sat;

	// One digit of each square root per cycle
	always_comb begin
		ta = ra_q + bit_q;
		tb = rb_q + bit_q;
		if (xa_q >= ta) begin
			xa_n = xa_q - ta;
			ra_n = (ra_q >> 1) + bit_q;
		end else begin
			xa_n = xa_q;
			ra_n = ra_q >> 1;
		end
		if (xb_q >= tb) begin
			xb_n = xb_q - tb;
			rb_n = (rb_q >> 1) + bit_q;
		end else begin
			xb_n = xb_q;
			rb_n = rb_q >> 1;
		end
	end

	// Shift-add product and one quotient bit per cycle
	always_comb begin
		den_n  = mplr_q[0] ? den_q + mcand_q : den_q;
		rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
		if (rem_sh >= {1'b0, den_q}) begin
			rem_n = rem_sh - {1'b0, den_q};
			quo_n = {quo_q[NUM_W-2:0], 1'b1};
		end else begin
			rem_n = rem_sh;
			quo_n = {quo_q[NUM_W-2:0], 1'b0};
		end
		mag = dot[ACC_W-1] ? ACC_W'(-dot) : ACC_W'(dot);
	end

	// Saturate the final quotient into Q1.15
	always_comb begin
		if (neg_q) begin
			sat = (quo_n > NUM_W'(32768)) ? SCORE_MIN : 16'(-quo_n[15:0]);
		end else begin
			sat = (quo_n > NUM_W'(32767)) ? SCORE_MAX : 16'(quo_n[15:0]);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (go) begin
						if (na == '0 || nb == '0) begin
							done <= 1'b1;
						end else begin
							st_q <= ST_SQRT;
						end
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						st_q <= ST_IDLE;
						done <= 1'b1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				score   <= SCORE_MIN;
				xa_q    <= SQ_W'(na);
				xb_q    <= SQ_W'(nb);
				ra_q    <= '0;
				rb_q    <= '0;
				bit_q   <= SQ_W'(1) << (SQ_W - 2);
				cnt_q   <= CW'(RT_W - 1);
				neg_q   <= dot[ACC_W-1];
				num_q   <= {mag, 15'd0};
			end
			ST_SQRT: begin
				xa_q  <= xa_n;
				xb_q  <= xb_n;
				ra_q  <= ra_n;
				rb_q  <= rb_n;
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					mcand_q <= DEN_W'(ra_n[RT_W-1:0]);
					mplr_q  <= rb_n[RT_W-1:0];
					den_q   <= '0;
					cnt_q   <= CW'(RT_W - 1);
				end
			end
			ST_MUL: begin
				den_q   <= den_n;
				mcand_q <= mcand_q << 1;
				mplr_q  <= mplr_q >> 1;
				cnt_q   <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= CW'(NUM_W - 1);
				end
			end
			ST_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				num_q <= num_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					score <= sat;
				end
			end
			default: cnt_q <= '0;
		endcase
	end
endmodule

@@ rtl/core/cosine_best_match_search_top.sv @@
// Top level: vector stores, element pipeline and best-match sequencer.
//
// Enrolled-element and probe-element beats leave busy low, so the next beat may
// follow at once. A probe beat with last set starts the search and holds busy
// until the result appears, which is in the same cycle that busy drops. The
// search reads each active entry against the probe over the vector length, one
// element per cycle from the single read port of each store, and then scores
// it with the bit-serial square roots, product and divide; an entry with a zero
// norm skips those. With no active entry or a length mismatch the search goes
// straight to the result without reading either store.
// The result is shown for one cycle with done high and cannot be held off.
module cosine_best_match_search_top import cbms_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int EMBED_LEN   = EMBED_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_beat_t   in_beat,
	output logic       done,
	output res_beat_t  res,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int EDEPTH = MAX_ENTRIES * EMBED_LEN;
	localparam int EAW    = EDEPTH > 1 ? $clog2(EDEPTH) : 1;
	localparam int PAW    = EMBED_LEN > 1 ? $clog2(EMBED_LEN) : 1;
	localparam int EW     = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
	localparam int NW     = $clog2(MAX_ENTRIES + 1);
	localparam int PCW    = $clog2(EMBED_LEN + 2);
	localparam int ACC_W  = 32 + $clog2(EMBED_LEN);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_SCORE = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]  state_q;
	logic [6:0]  entry_count_q;
	logic [9:0]  vector_length_q;
	logic signed [15:0] thresh_q;
	logic [PCW-1:0] probe_count_q, probe_count_n;

	logic           accept, e_we;
	logic [EAW-1:0] e_waddr, e_raddr, base_q;
	logic [PAW-1:0] i_q;
	logic [15:0]    e_rdata, p_rdata;
	logic [EW-1:0]  e_q, best_e_q;
	logic [NW-1:0]  n_q;
	logic           found_q;
	logic signed [15:0] best_q;

	logic           rd_v_s1, v_s2;
	logic signed [31:0] pd_s2;
	logic [31:0]    pa_s2, pb_s2;
	logic signed [ACC_W-1:0] dot_q;
	logic [ACC_W-1:0] na_q, nb_q;

	logic           sc_go, sc_done;
	logic signed [15:0] sc_score;

	logic [31:0] n_calc, len32;
	logic        len_ok;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign len32  = 32'(vector_length_q);

	// Load address and search start checks
	always_comb begin
		e_we    = accept && !in_beat.kind && (32'(in_beat.entry) < 32'(MAX_ENTRIES))
			&& (32'(in_beat.position) < 32'(EMBED_LEN));
		e_waddr = EAW'(32'(in_beat.entry) * 32'(EMBED_LEN) + 32'(in_beat.position));
		probe_count_n = (32'(probe_count_q) <= 32'(EMBED_LEN)) ? probe_count_q + 1'b1
			: probe_count_q;
		n_calc  = (32'(entry_count_q) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES)
			: 32'(entry_count_q);
		len_ok  = (len32 != 0) && (len32 <= 32'(EMBED_LEN))
			&& (32'(probe_count_n) == len32);
		e_raddr = base_q + EAW'(i_q);
	end

	cbms_ram #(.WIDTH(16), .DEPTH(EDEPTH)) u_enrolled (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (in_beat.value),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	cbms_ram #(.WIDTH(16), .DEPTH(EMBED_LEN)) u_probe (
		.clk   (clk),
		.we    (accept && in_beat.kind && (32'(probe_count_q) < 32'(EMBED_LEN))),
		.waddr (PAW'(probe_count_q)),
		.wdata (in_beat.value),
		.raddr (i_q),
		.rdata (p_rdata)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q   <= '0;
			vector_length_q <= 10'd512;
			thresh_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENTRY_COUNT:   entry_count_q   <= cfg_data[6:0];
				CFG_VECTOR_LENGTH: vector_length_q <= cfg_data[9:0];
				CFG_MATCH_THRESH:  thresh_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Element products, one stage after the reads
	always_ff @(posedge clk) begin
		pd_s2 <= $signed(e_rdata) * $signed(p_rdata);
		pa_s2 <= 32'($signed(e_rdata) * $signed(e_rdata));
		pb_s2 <= 32'($signed(p_rdata) * $signed(p_rdata));
	end

	// Accumulators
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE || (state_q == ST_SCORE && sc_done)) begin
			dot_q <= '0;
			na_q  <= '0;
			nb_q  <= '0;
		end else if (v_s2) begin
			dot_q <= dot_q + ACC_W'(pd_s2);
			na_q  <= na_q + ACC_W'(pa_s2);
			nb_q  <= nb_q + ACC_W'(pb_s2);
		end
	end

	assign sc_go = (state_q == ST_DRAIN) && !rd_v_s1 && !v_s2;

	cbms_score #(.ACC_W(ACC_W)) u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sc_go),
		.dot    (dot_q),
		.na     (na_q),
		.nb     (nb_q),
		.done   (sc_done),
		.score  (sc_score)
	);

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			probe_count_q <= '0;
			rd_v_s1       <= 1'b0;
			v_s2          <= 1'b0;
			done          <= 1'b0;
		end else begin
			done    <= 1'b0;
			rd_v_s1 <= (state_q == ST_RUN);
			v_s2    <= rd_v_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_beat.kind) begin
						probe_count_q <= probe_count_n;
						if (in_beat.last) begin
							state_q <= (n_calc == 0 || !len_ok) ? ST_EMIT : ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (32'(i_q) + 1 == len32) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (sc_go) begin
						state_q <= ST_SCORE;
					end
				end
				ST_SCORE: begin
					if (sc_done) begin
						state_q <= (32'(e_q) + 1 == 32'(n_q)) ? ST_EMIT : ST_RUN;
					end
				end
				ST_EMIT: begin
					done          <= 1'b1;
					probe_count_q <= '0;
					state_q       <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Search payload: counters, best score, result beat
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				i_q      <= '0;
				e_q      <= '0;
				base_q   <= '0;
				n_q      <= NW'(n_calc);
				best_q   <= SCORE_MIN;
				best_e_q <= '0;
				found_q  <= 1'b0;
			end
			ST_RUN: begin
				i_q <= i_q + 1'b1;
			end
			ST_SCORE: begin
				if (sc_done) begin
					if (sc_score > best_q) begin
						best_q   <= sc_score;
						best_e_q <= e_q;
						found_q  <= 1'b1;
					end
					i_q    <= '0;
					e_q    <= e_q + 1'b1;
					base_q <= base_q + EAW'(EMBED_LEN);
				end
			end
			ST_EMIT: begin
				res.matched    <= found_q && (best_q >= thresh_q);
				res.best_entry <= 6'(best_e_q);
				res.score      <= best_q;
			end
			default: i_q <= i_q;
		endcase
	end

	// Checks
	a_done_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_EMIT)
		else $error("result beat without a finished search");
	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_beat.kind && in_beat.last |=> busy)
		else $error("last probe beat did not start a search");
	a_read_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> $past(state_q) == ST_RUN)
		else $error("element read outside the run phase");
	a_score_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sc_done |-> state_q == ST_SCORE)
		else $error("score finished outside the score phase");
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> probe_count_q == '0)
		else $error("probe count not cleared after a search");
endmodule

@@ tb/cbms_checker.sv @@
// Checker for the cosine best-match search: shadow stores, score prediction and result compare.
`timescale 1ns / 100ps

module cbms_checker import cbms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  in_beat_t    in_beat,
	input  logic        done,
	input  res_beat_t   res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);

	localparam logic KIND_LOAD  = 1'b0;
	localparam int   N_ENT      = MAX_ENTRIES_DEF;
	localparam int   N_LEN      = EMBED_LEN_DEF;

	// shadow state
	logic signed [15:0] gallery [0:N_ENT*N_LEN-1];
	logic signed [15:0] probe_vec [0:N_LEN-1];
	int                 probe_len;
	logic [6:0]         active_cnt;
	logic [9:0]         vec_len;
	logic signed [15:0] thresh;
	res_beat_t          match_q [$];

	assign pending = match_q.size();

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// cosine of the probe against one enrolled entry, Q1.15 saturating
	function automatic logic signed [15:0] cosine_q15(int e, int len);
		longint          dot;
		longint unsigned na, nb, mag, q;
		longint          a, b;
		dot = 0;
		na  = 0;
		nb  = 0;
		for (int i = 0; i < len; i++) begin
			a = gallery[e*N_LEN+i];
			b = probe_vec[i];
			dot += a * b;
			na  += a * a;
			nb  += b * b;
		end
		if (na == 0 || nb == 0) return SCORE_MIN;
		mag = (dot < 0) ? -dot : dot;
		q = (mag * 64'd32768) / (floor_sqrt(na) * floor_sqrt(nb));
		if (dot < 0) begin
			if (q > 32768) q = 32768;
			return -$signed(q[16:0]);
		end
		if (q > 32767) q = 32767;
		return q[15:0];
	endfunction

	// walk the active entries, first strictly greater score wins
	function automatic res_beat_t best_match();
		res_beat_t          r;
		int                 n;
		logic               len_ok, found;
		logic signed [15:0] best, s;
		n      = (active_cnt > N_ENT) ? N_ENT : active_cnt;
		len_ok = vec_len != 0 && vec_len <= N_LEN && probe_len == vec_len;
		best   = SCORE_MIN;
		found  = 1'b0;
		r.best_entry = '0;
		for (int e = 0; e < n; e++) begin
			s = len_ok ? cosine_q15(e, vec_len) : SCORE_MIN;
			if (s > best) begin
				best  = s;
				r.best_entry = e[5:0];
				found = 1'b1;
			end
		end
		r.score   = best;
		r.matched = found && best >= thresh;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_beat_t want;
		int        bad;
		bad = 0;
		if (!arst_n) begin
			errors     <= 0;
			probe_len  = 0;
			active_cnt = 7'd0;
			vec_len    = 10'd512;
			thresh     = 16'sd0;
			match_q.delete();
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENTRY_COUNT:   active_cnt = cfg_data[6:0];
					CFG_VECTOR_LENGTH: vec_len    = cfg_data[9:0];
					CFG_MATCH_THRESH:  thresh     = cfg_data;
					default: ;
				endcase
			end
			// result beat against the oldest expectation
			if (done) begin
				if (match_q.size() == 0) begin
					$display("%0t: unexpected result matched=%0b entry=%0d score=%0d",
						$time, res.matched, res.best_entry, res.score);
					bad++;
				end else begin
					want = match_q.pop_front();
					if (res.matched !== want.matched) begin
						$display("%0t: matched exp %0b got %0b", $time, want.matched,
							res.matched);
						bad++;
					end
					if (res.best_entry !== want.best_entry) begin
						$display("%0t: best_entry exp %0d got %0d", $time,
							want.best_entry, res.best_entry);
						bad++;
					end
					if (res.score !== want.score) begin
						$display("%0t: score exp %0d got %0d", $time, want.score,
							res.score);
						bad++;
					end
				end
			end
			if (bad != 0) errors <= errors + bad;
			// accepted input beat
			if (start && !busy) begin
				if (in_beat.kind == KIND_LOAD) begin
					gallery[in_beat.entry*N_LEN+in_beat.position] = in_beat.value;
				end else begin
					if (probe_len < N_LEN) probe_vec[probe_len] = in_beat.value;
					if (probe_len <= N_LEN) probe_len++;
					if (in_beat.last) begin
						match_q.push_back(best_match());
						probe_len = 0;
					end
				end
			end
		end
	end

endmodule

@@ tb/cosine_best_match_search_top_tb.sv @@
// Testbench top: clock, reset, stimulus, idle gaps, watchdog and verdict.
`timescale 1ns / 100ps

module cosine_best_match_search_top_tb;
	import cbms_pkg::*;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_PROBE = 1'b1;
	localparam int   N_LEN      = EMBED_LEN_DEF;
	localparam int   IDLE_LIMIT = 60000;
	localparam int   N_PHASE    = 9;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_beat_t    in_beat = '0;
	logic        done;
	res_beat_t   res;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_ENTRY_COUNT;
	logic [15:0] cfg_data = '0;
	int          errors, pending;
	int          idle_cycles = 0;
	int          burst_left = 0;
	bit          written [0:MAX_ENTRIES_DEF*N_LEN-1];

	// phase table: active entries, vector length, threshold
	int n_tab [N_PHASE] = '{1, 3, 64, 127, 4, 5, 0, 8, 6};
	int l_tab [N_PHASE] = '{4, 8, 1, 2, 16, 3, 7, 0, 1023};
	int t_tab [N_PHASE] = '{0, -32768, 32767, -100, 16000, 20000, 0, -5, 1};

	cosine_best_match_search_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_beat(in_beat),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cbms_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_beat(in_beat),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(7))
			0: return SCORE_MIN;
			1: return SCORE_MAX;
			2: return 16'sd0;
			3: return $signed(16'($urandom_range(8))) - 16'sd4;
			default: return 16'($urandom);
		endcase
	endfunction

	// drive one beat and hold it until accepted, then maybe leave a gap
	task automatic send(input logic kind, input int ent, input int pos,
			input logic signed [15:0] val, input logic lst);
		start          = 1'b1;
		in_beat.kind   = kind;
		in_beat.entry  = ent[5:0];
		in_beat.position = pos[8:0];
		in_beat.value  = val;
		in_beat.last   = lst;
		do @(posedge clk); while (busy);
		if (kind == KIND_LOAD) written[ent[5:0]*N_LEN+pos[8:0]] = 1'b1;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(40, 1);
			if ($urandom_range(3) != 0) begin
				start = 1'b0;
				repeat ($urandom_range(8, 1)) @(negedge clk);
			end
		end
	endtask

	task automatic load(input int ent, input int pos);
		send(KIND_LOAD, ent, pos, pick_value(), 1'($urandom));
	endtask

	// probe vector of a given length, content random
	task automatic probe(input int len);
		for (int i = 0; i < len; i++)
			send(KIND_PROBE, $urandom, $urandom, pick_value(), i == len - 1);
	endtask

	task automatic wait_idle();
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input int val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val[15:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// make sure every element the search reads was written
	task automatic fill(input int n, input int len);
		int ne;
		ne = (n > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : n;
		if (len < 1 || len > N_LEN) return;
		for (int e = 0; e < ne; e++)
			for (int p = 0; p < len; p++)
				if (!written[e*N_LEN+p]) load(e, p);
	endtask

	initial begin
		int ne, plen;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default registers: nothing active, result is minus one with no match
		probe(1);
		wait_idle();

		// zero norm, ties, saturation and the minus one score never chosen
		cfg_write(CFG_ENTRY_COUNT, 3);
		cfg_write(CFG_VECTOR_LENGTH, 2);
		cfg_write(CFG_MATCH_THRESH, -32768);
		send(KIND_LOAD, 0, 0, 16'sd0, 1'b1);
		send(KIND_LOAD, 0, 1, 16'sd0, 1'b0);
		send(KIND_LOAD, 1, 0, SCORE_MAX, 1'b0);
		send(KIND_LOAD, 1, 1, SCORE_MIN, 1'b0);
		send(KIND_LOAD, 2, 0, SCORE_MAX, 1'b0);
		send(KIND_LOAD, 2, 1, SCORE_MIN, 1'b1);
		send(KIND_PROBE, 63, 511, SCORE_MAX, 1'b0);
		send(KIND_PROBE, 0, 0, SCORE_MIN, 1'b1);
		send(KIND_PROBE, 0, 0, SCORE_MIN, 1'b0);
		send(KIND_PROBE, 0, 0, SCORE_MAX, 1'b1);
		send(KIND_PROBE, 0, 0, 16'sd0, 1'b0);
		send(KIND_PROBE, 0, 0, 16'sd0, 1'b1);
		send(KIND_PROBE, 0, 0, 16'sd1, 1'b1);
		send(KIND_PROBE, 0, 0, 16'sd1, 1'b0);
		send(KIND_PROBE, 0, 0, 16'sd1, 1'b0);
		send(KIND_PROBE, 0, 0, 16'sd1, 1'b1);
		wait_idle();

		// random phases over register settings
		for (int ph = 0; ph < N_PHASE; ph++) begin
			cfg_write(CFG_ENTRY_COUNT, n_tab[ph]);
			cfg_write(CFG_VECTOR_LENGTH, l_tab[ph]);
			cfg_write(CFG_MATCH_THRESH, t_tab[ph]);
			fill(n_tab[ph], l_tab[ph]);
			ne = (n_tab[ph] > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : n_tab[ph];
			for (int k = 0; k < 8; k++) begin
				// reload a few elements in the active area or anywhere
				repeat ($urandom_range(4)) begin
					if (ne > 0 && l_tab[ph] >= 1 && l_tab[ph] <= N_LEN &&
							$urandom_range(9) < 7)
						load($urandom_range(ne - 1), $urandom_range(l_tab[ph] - 1));
					else
						load($urandom_range(63), $urandom_range(N_LEN - 1));
				end
				if (l_tab[ph] < 1 || l_tab[ph] > N_LEN) plen = $urandom_range(12, 1);
				else case ($urandom_range(9))
					0: plen = (l_tab[ph] > 1) ? l_tab[ph] - 1 : 2;
					1: plen = l_tab[ph] + 1;
					default: plen = l_tab[ph];
				endcase
				probe(plen);
			end
			wait_idle();
		end

		// overlong probe: the count sticks past the store and the length mismatches
		cfg_write(CFG_ENTRY_COUNT, 1);
		cfg_write(CFG_VECTOR_LENGTH, N_LEN);
		cfg_write(CFG_MATCH_THRESH, 0);
		probe(N_LEN + 2);
		wait_idle();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/cbms_pkg.sv
rtl/core/cbms_ram.sv
rtl/core/cbms_score.sv
rtl/core/cosine_best_match_search_top.sv
tb/cbms_checker.sv
tb/cosine_best_match_search_top_tb.sv
